[hw/rtl/srps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types and constants of the SimRank partial-sums engine.
// ----------------------------------------------------------------------------
package srps_pkg;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned VW           = 8;   // vertex id bits
  localparam int unsigned NW           = 9;   // vertex count bits
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned SCORE_W      = FRAC_BITS + 1;
  localparam int unsigned DECAY_W      = 17;

  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_BITS;
  localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

  typedef enum logic [1:0] {
    REQ_LOAD_OFFSET = 2'd0,
    REQ_LOAD_EDGE   = 2'd1,
    REQ_RUN         = 2'd2,
    REQ_QUERY       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_STEP_COUNT   = 2'd1,
    CFG_DECAY        = 2'd2,
    CFG_HALF_MODE    = 2'd3
  } cfg_e;

  typedef enum logic {
    KIND_RUN_DONE = 1'b0,
    KIND_QUERY    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] slot;
    logic [12:0] value;
    logic [7:0]  query_vertex;
    logic [7:0]  other_vertex;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] score;
  } out_item_t;

endpackage

[hw/rtl/srps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/simrank_partial_sums_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simrank_partial_sums_engine_top
// SimRank engine over a compressed in-neighbour graph with partial-sum reuse.
// ----------------------------------------------------------------------------
// Load transactions (offset or edge) are written from the idle state; a query
// reads the score RAM and returns its registered read data. After reset, and at the
// start of every run, a clearing pass walks the 65536 score addresses, one a
// cycle, while no transaction is accepted. A run then iterates step_count
// times over the pairs a<b of the live vertices. Each row a first reads its
// offsets. Each pair reads the offsets of b, then walks the neighbours of b,
// adding a cached partial sum where there is one, and for each newly seen
// partial sum walks the neighbours of a. It then runs the shared serial
// multiply (17 steps) and restoring divide (60 steps at the default edge
// count), both skipped when a degree is zero. Only the upper triangle of each
// score bank is computed and read, so half mode gives the same scores as full
// mode.
// ----------------------------------------------------------------------------
module simrank_partial_sums_engine_top
  import srps_pkg::*;
#(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned DW  = 2 * EW;
  localparam int unsigned PW  = EW + FRAC_BITS + 1;
  localparam int unsigned TW  = DW + FRAC_BITS + 1;
  localparam int unsigned NWD = TW + DECAY_W;
  localparam int unsigned CW  = $clog2(NWD);
  localparam int unsigned BAW = 2 * VW;
  localparam int unsigned EIW = VW + 1;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_CLR   = 21'h000002,
    S_IT    = 21'h000004,
    S_OA0   = 21'h000008,
    S_OA1   = 21'h000010,
    S_OA2   = 21'h000020,
    S_BS    = 21'h000040,
    S_OB1   = 21'h000080,
    S_OB2   = 21'h000100,
    S_IL    = 21'h000200,
    S_IW    = 21'h000400,
    S_PW    = 21'h000800,
    S_JL    = 21'h001000,
    S_JE    = 21'h002000,
    S_JB    = 21'h004000,
    S_DEN   = 21'h008000,
    S_MUL   = 21'h010000,
    S_DIV   = 21'h020000,
    S_WR    = 21'h040000,
    S_RDONE = 21'h080000,
    S_QOUT  = 21'h100000
  } state_e;

  // configuration
  logic [NW-1:0]      vcount_q;
  logic [5:0]         steps_q;
  logic [DECAY_W-1:0] decay_q;

  // control
  state_e            state_q, state_d;
  logic              run_pend_q, run_pend_d;
  logic [BAW-1:0]    clr_q, clr_d;
  logic [5:0]        it_q, it_d;
  logic [NW-1:0]     a_q, a_d, b_q, b_d;
  logic [EW-1:0]     i_q, i_d, j_q, j_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [MAX_VERTICES-1:0] flags_q, flags_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [EW-1:0]      alo_q, alo_d, ahi_q, ahi_d, blo_q, blo_d, bhi_q, bhi_d;
  logic [VW-1:0]      nb_q, nb_d;
  logic [PW-1:0]      ps_q, ps_d;
  logic [TW-1:0]      total_q, total_d;
  logic [DW-1:0]      den_q, den_d;
  logic [NWD-1:0]     acc_q, acc_d, mcand_q, mcand_d, num_q, num_d;
  logic [DECAY_W-1:0] mplier_q, mplier_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [SCORE_W-1:0] res_q, res_d;
  logic               qzero_q, qzero_d, qsel_q, qsel_d;
  out_item_t          out_q, out_d;

  // memories
  logic               off_we, off_re;
  logic [NW-1:0]      off_waddr, off_raddr;
  logic [EW-1:0]      off_wdata, off_rdata;
  logic               edge_we, edge_re;
  logic [EAW-1:0]     edge_waddr, edge_raddr;
  logic [EIW-1:0]     edge_wdata, edge_rdata;
  logic               ps_we, ps_re;
  logic [VW-1:0]      ps_waddr, ps_raddr;
  logic [PW-1:0]      ps_wdata, ps_rdata;
  logic               bk_we0, bk_we1, bk_re;
  logic [BAW-1:0]     bk_waddr, bk_raddr;
  logic [SCORE_W-1:0] bk_wdata, bk_rdata0, bk_rdata1;

  // helpers
  logic [NW-1:0]      n_live;
  logic [DECAY_W-1:0] dec_sat;
  logic               in_acc, out_acc, out_free;
  logic [EW-1:0]      deg_a, deg_b;
  logic [VW-1:0]      e_id;
  logic               e_ok;
  logic [DW:0]        trial;
  logic               ge;
  logic [NWD-1:0]     qshift, acc_next;
  logic [SCORE_W-1:0] bk_src;

  srps_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(off_waddr), .wdata_i(off_wdata),
    .re_i(off_re), .raddr_i(off_raddr), .rdata_o(off_rdata)
  );

  srps_ram #(.WIDTH(EIW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  srps_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_psum_ram (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(ps_wdata),
    .re_i(ps_re), .raddr_i(ps_raddr), .rdata_o(ps_rdata)
  );

  srps_ram #(.WIDTH(SCORE_W), .DEPTH(1 << BAW)) u_bank0_ram (
    .clk_i, .we_i(bk_we0), .waddr_i(bk_waddr), .wdata_i(bk_wdata),
    .re_i(bk_re), .raddr_i(bk_raddr), .rdata_o(bk_rdata0)
  );

  srps_ram #(.WIDTH(SCORE_W), .DEPTH(1 << BAW)) u_bank1_ram (
    .clk_i, .we_i(bk_we1), .waddr_i(bk_waddr), .wdata_i(bk_wdata),
    .re_i(bk_re), .raddr_i(bk_raddr), .rdata_o(bk_rdata1)
  );

  assign n_live   = (vcount_q == '0) ? NW'(1) :
                    ((32'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : vcount_q);
  assign dec_sat  = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign deg_a    = ahi_q - alo_q;
  assign deg_b    = bhi_q - blo_q;
  assign e_id     = edge_rdata[VW-1:0];
  assign e_ok     = !edge_rdata[VW] && (NW'(e_id) < n_live);
  assign trial    = {rem_q, num_q[NWD-1]};
  assign ge       = (trial >= {1'b0, den_q});
  assign acc_next = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
  assign qshift   = {num_q[NWD-2:0], ge} >> 16;
  assign bk_src   = it_q[0] ? bk_rdata1 : bk_rdata0;

  always_comb begin
    state_d     = state_q;
    run_pend_d  = run_pend_q;
    clr_d       = clr_q;
    it_d        = it_q;
    a_d         = a_q;
    b_d         = b_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q && !out_acc;
    alo_d       = alo_q;
    ahi_d       = ahi_q;
    blo_d       = blo_q;
    bhi_d       = bhi_q;
    nb_d        = nb_q;
    ps_d        = ps_q;
    total_d     = total_q;
    den_d       = den_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    num_d       = num_q;
    rem_d       = rem_q;
    res_d       = res_q;
    qzero_d     = qzero_q;
    qsel_d      = qsel_q;
    out_d       = out_q;

    off_we     = 1'b0;
    off_waddr  = in_data_i.slot[NW-1:0];
    off_wdata  = (32'(in_data_i.value) > MAX_EDGES) ? EW'(MAX_EDGES) :
                 EW'(in_data_i.value);
    off_re     = 1'b0;
    off_raddr  = a_q;
    edge_we    = 1'b0;
    edge_waddr = EAW'(in_data_i.slot);
    edge_wdata = {(32'(in_data_i.value) >= MAX_VERTICES), in_data_i.value[VW-1:0]};
    edge_re    = 1'b0;
    edge_raddr = i_q[EAW-1:0];
    ps_we      = 1'b0;
    ps_waddr   = nb_q;
    ps_wdata   = ps_q;
    ps_re      = 1'b0;
    ps_raddr   = e_id;
    bk_we0     = 1'b0;
    bk_we1     = 1'b0;
    bk_waddr   = {a_q[VW-1:0], b_q[VW-1:0]};
    bk_wdata   = res_q;
    bk_re      = 1'b0;
    bk_raddr   = (e_id < nb_q) ? {e_id, nb_q} : {nb_q, e_id};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.req_type)
            REQ_LOAD_OFFSET: off_we = (32'(in_data_i.slot) <= MAX_VERTICES);
            REQ_LOAD_EDGE:   edge_we = (32'(in_data_i.slot) < MAX_EDGES);
            REQ_RUN: begin
              run_pend_d = 1'b1;
              clr_d      = '0;
              state_d    = S_CLR;
            end
            REQ_QUERY: begin
              bk_re    = 1'b1;
              bk_raddr = (in_data_i.query_vertex < in_data_i.other_vertex) ?
                         {in_data_i.query_vertex, in_data_i.other_vertex} :
                         {in_data_i.other_vertex, in_data_i.query_vertex};
              qzero_d  = (in_data_i.query_vertex == in_data_i.other_vertex) ||
                         ({1'b0, in_data_i.query_vertex} >= n_live) ||
                         ({1'b0, in_data_i.other_vertex} >= n_live);
              qsel_d   = steps_q[0];
              state_d  = S_QOUT;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        bk_we0   = 1'b1;
        bk_we1   = 1'b1;
        bk_waddr = clr_q;
        bk_wdata = '0;
        clr_d    = clr_q + BAW'(1);
        if (clr_q == '1) begin
          it_d    = '0;
          state_d = run_pend_q ? S_IT : S_IDLE;
        end
      end
      S_IT: begin
        if (it_q >= steps_q) begin
          state_d = S_RDONE;
        end else begin
          a_d     = '0;
          state_d = S_OA0;
        end
      end
      S_OA0: begin
        off_re  = 1'b1;
        state_d = S_OA1;
      end
      S_OA1: begin
        off_re    = 1'b1;
        off_raddr = a_q + NW'(1);
        alo_d     = off_rdata;
        state_d   = S_OA2;
      end
      S_OA2: begin
        ahi_d   = (off_rdata < alo_q) ? alo_q : off_rdata;
        flags_d = '0;
        b_d     = a_q + NW'(1);
        state_d = S_BS;
      end
      S_BS: begin
        if (b_q >= n_live) begin
          a_d = a_q + NW'(1);
          if (a_q + NW'(1) >= n_live) begin
            it_d    = it_q + 6'd1;
            state_d = S_IT;
          end else begin
            state_d = S_OA0;
          end
        end else begin
          off_re    = 1'b1;
          off_raddr = b_q;
          state_d   = S_OB1;
        end
      end
      S_OB1: begin
        off_re    = 1'b1;
        off_raddr = b_q + NW'(1);
        blo_d     = off_rdata;
        state_d   = S_OB2;
      end
      S_OB2: begin
        bhi_d   = (off_rdata < blo_q) ? blo_q : off_rdata;
        i_d     = blo_q;
        total_d = '0;
        state_d = S_IL;
      end
      S_IL: begin
        if (i_q >= bhi_q) begin
          state_d = S_DEN;
        end else begin
          edge_re = 1'b1;
          state_d = S_IW;
        end
      end
      S_IW: begin
        nb_d = e_id;
        if (!e_ok) begin
          i_d     = i_q + EW'(1);
          state_d = S_IL;
        end else if (flags_q[e_id]) begin
          ps_re   = 1'b1;
          state_d = S_PW;
        end else begin
          ps_d    = '0;
          j_d     = alo_q;
          state_d = S_JL;
        end
      end
      S_PW: begin
        total_d = total_q + TW'(ps_rdata);
        i_d     = i_q + EW'(1);
        state_d = S_IL;
      end
      S_JL: begin
        if (j_q >= ahi_q) begin
          ps_we          = 1'b1;
          flags_d[nb_q]  = 1'b1;
          total_d        = total_q + TW'(ps_q);
          i_d            = i_q + EW'(1);
          state_d        = S_IL;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = j_q[EAW-1:0];
          state_d    = S_JE;
        end
      end
      S_JE: begin
        if (!e_ok) begin
          j_d     = j_q + EW'(1);
          state_d = S_JL;
        end else if (e_id == nb_q) begin
          ps_d    = ps_q + PW'(SCORE_ONE);
          j_d     = j_q + EW'(1);
          state_d = S_JL;
        end else begin
          bk_re   = 1'b1;
          state_d = S_JB;
        end
      end
      S_JB: begin
        ps_d    = ps_q + PW'(bk_src);
        j_d     = j_q + EW'(1);
        state_d = S_JL;
      end
      S_DEN: begin
        den_d    = DW'(deg_a) * DW'(deg_b);
        acc_d    = '0;
        mcand_d  = NWD'(total_q);
        mplier_d = dec_sat;
        cnt_d    = '0;
        if (den_d == '0) begin
          res_d   = '0;
          state_d = S_WR;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        acc_d    = acc_next;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(DECAY_W - 1)) begin
          num_d   = acc_next;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
        num_d = {num_q[NWD-2:0], ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NWD - 1)) begin
          res_d   = (qshift > NWD'(SCORE_ONE)) ? SCORE_ONE : qshift[SCORE_W-1:0];
          state_d = S_WR;
        end
      end
      S_WR: begin
        bk_we0  = it_q[0];
        bk_we1  = !it_q[0];
        b_d     = b_q + NW'(1);
        state_d = S_BS;
      end
      S_RDONE: begin
        if (out_free) begin
          out_d       = '{kind: KIND_RUN_DONE, score: '0};
          out_valid_d = 1'b1;
          run_pend_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          out_d.kind  = KIND_QUERY;
          out_d.score = qzero_q ? '0 : (qsel_q ? bk_rdata1 : bk_rdata0);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= NW'(256);
      steps_q     <= 6'd5;
      decay_q     <= 17'd39322;
      state_q     <= S_CLR;
      run_pend_q  <= 1'b0;
      clr_q       <= '0;
      it_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VERTEX_COUNT: vcount_q <= cfg_data_i[NW-1:0];
          CFG_STEP_COUNT:   steps_q  <= cfg_data_i[5:0];
          CFG_DECAY:        decay_q  <= cfg_data_i;
          CFG_HALF_MODE:    ;  // only the upper triangle is ever computed
          default: ;
        endcase
      end
      state_q     <= state_d;
      run_pend_q  <= run_pend_d;
      clr_q       <= clr_d;
      it_q        <= it_d;
      a_q         <= a_d;
      b_q         <= b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alo_q    <= alo_d;
    ahi_q    <= ahi_d;
    blo_q    <= blo_d;
    bhi_q    <= bhi_d;
    nb_q     <= nb_d;
    ps_q     <= ps_d;
    total_q  <= total_d;
    den_q    <= den_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    qzero_q  <= qzero_d;
    qsel_q   <= qsel_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RDONE || state_q == S_QOUT))
    else $error("result raised outside a result state");

  a_upper_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (a_q < b_q) && (b_q < n_live))
    else $error("score write outside the upper triangle");

  a_psum_cached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PW) |-> flags_q[nb_q])
    else $error("partial sum read before it was computed");

endmodule

[bench/simrank_partial_sums_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simrank_partial_sums_engine_top_test
// Self-checking bench for the SimRank partial-sums engine. Small graphs are
// loaded as offset and edge transactions, runs are started under several
// register settings, and pair queries are compared with a local predictor.
// Random noise loads and random idle and stall cycles fill the rest.
// ----------------------------------------------------------------------------
module simrank_partial_sums_engine_top_test;
  import srps_pkg::*;

  localparam int EDGE_DEPTH  = 4096;
  localparam int CYCLE_LIMIT = 6000000;

  class score_board;
    bit [16:0]   bank[2][MAX_VERTICES][MAX_VERTICES];
    int unsigned offs[MAX_VERTICES + 1];
    int unsigned edges[EDGE_DEPTH];
    longint      psum[MAX_VERTICES];
    bit          seen[MAX_VERTICES];
    int unsigned vcount = 256, steps = 5, decay = 39322, half = 0;
    out_item_t   pending[$];
    int          errors = 0;

    function new();
      identity();
    endfunction

    function void identity();
      for (int k = 0; k < 2; k++)
        for (int x = 0; x < MAX_VERTICES; x++)
          for (int y = 0; y < MAX_VERTICES; y++)
            bank[k][x][y] = (x == y) ? SCORE_ONE : '0;
    endfunction

    function int unsigned live();
      if (vcount < 1) return 1;
      if (vcount > MAX_VERTICES) return MAX_VERTICES;
      return vcount;
    endfunction

    function void span(int unsigned v, output int unsigned lo, output int unsigned hi);
      lo = (offs[v] > EDGE_DEPTH) ? EDGE_DEPTH : offs[v];
      hi = (offs[v+1] > EDGE_DEPTH) ? EDGE_DEPTH : offs[v+1];
      if (hi < lo) hi = lo;
    endfunction

    function longint pair(int unsigned k, int unsigned x, int unsigned y, int unsigned n);
      if (x >= n || y >= n) return 0;
      if (x == y) return SCORE_ONE;
      if (x > y) return bank[k & 1][y][x];
      return bank[k & 1][x][y];
    endfunction

    function void iterate();
      int unsigned n, dec, src, dst, alo, ahi, blo, bhi, nb;
      longint total, den, q, r, res;
      n = live();
      dec = (decay > 65536) ? 65536 : decay;
      identity();
      for (int it = 0; it < steps; it++) begin
        src = it & 1;
        dst = src ^ 1;
        for (int x = 0; x < n; x++)
          for (int y = 0; y < n; y++)
            if (x != y) bank[dst][x][y] = '0;
        for (int a = 0; a < n; a++) begin
          span(a, alo, ahi);
          for (int v = 0; v < MAX_VERTICES; v++) seen[v] = 0;
          for (int b = 0; b < n; b++) begin
            if (a == b) continue;
            if (half && a > b) continue;
            span(b, blo, bhi);
            total = 0;
            for (int i = blo; i < bhi; i++) begin
              nb = edges[i];
              if (nb >= n) continue;
              if (!seen[nb]) begin
                psum[nb] = 0;
                for (int j = alo; j < ahi; j++) psum[nb] += pair(src, edges[j], nb, n);
                seen[nb] = 1;
              end
              total += psum[nb];
            end
            den = longint'(ahi - alo) * longint'(bhi - blo);
            if (den == 0) begin
              res = 0;
            end else begin
              q = total / den;
              r = total % den;
              res = (q * dec + (r * dec) / den) >> 16;
              if (res > SCORE_ONE) res = SCORE_ONE;
            end
            bank[dst][a][b] = res[16:0];
          end
        end
      end
    endfunction

    function void write_reg(cfg_e idx, bit [16:0] val);
      case (idx)
        CFG_VERTEX_COUNT: vcount = val[8:0];
        CFG_STEP_COUNT:   steps  = val[5:0];
        CFG_DECAY:        decay  = val;
        CFG_HALF_MODE:    half   = val[0];
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      longint    s;
      case (it.req_type)
        REQ_LOAD_OFFSET: if (it.slot <= MAX_VERTICES) offs[it.slot] = it.value;
        REQ_LOAD_EDGE:   if (it.slot < EDGE_DEPTH) edges[it.slot] = it.value;
        REQ_RUN: begin
          iterate();
          o.kind = KIND_RUN_DONE;
          o.score = '0;
          pending.push_back(o);
        end
        default: begin
          o.kind = KIND_QUERY;
          s = 0;
          if (it.query_vertex != it.other_vertex)
            s = pair(steps, it.query_vertex, it.other_vertex, live());
          o.score = s[16:0];
          pending.push_back(o);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d score=%0d", $time, got.kind, got.score);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.score !== want.score) begin
        $display("%0t: score mismatch expected %0d actual %0d", $time, want.score, got.score);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_data;
  bit          no_idle = 0;
  int          cycles = 0;
  score_board  sb = new();

  simrank_partial_sums_engine_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !no_idle && ($urandom_range(0, 99) < 15);
  end

  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic send_load(req_e req, int unsigned slot, int unsigned val);
    in_item_t it;
    it = '0;
    it.req_type = req;
    it.slot = slot[12:0];
    it.value = val[12:0];
    it.query_vertex = 8'($urandom);
    it.other_vertex = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_query(int unsigned qv, int unsigned ov);
    in_item_t it;
    it = '0;
    it.req_type = REQ_QUERY;
    it.slot = 13'($urandom);
    it.value = 13'($urandom);
    it.query_vertex = qv[7:0];
    it.other_vertex = ov[7:0];
    send_item(it);
  endtask

  task automatic send_run();
    in_item_t it;
    it = '0;
    it.req_type = REQ_RUN;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, int unsigned val);
    drain();
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val[16:0];
    @(posedge clk_i);
    cfg_we <= 0;
    sb.write_reg(idx, val[16:0]);
  endtask

  task automatic build_graph(int unsigned n);
    int unsigned ptr, nxt, top, id;
    ptr = 0;
    top = 0;
    send_load(REQ_LOAD_OFFSET, 0, 0);
    for (int v = 0; v < n; v++) begin
      if (ptr > 0 && $urandom_range(0, 9) == 0) nxt = ptr - 1;
      else nxt = ptr + $urandom_range(0, 3);
      send_load(REQ_LOAD_OFFSET, v + 1, nxt);
      if (nxt > top) top = nxt;
      ptr = nxt;
    end
    for (int i = 0; i < top; i++) begin
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(n, 255) : $urandom_range(0, n - 1);
      send_load(REQ_LOAD_EDGE, i, id);
    end
  endtask

  task automatic random_query(int unsigned n);
    if ($urandom_range(0, 9) == 0) send_query($urandom_range(0, 255), $urandom_range(0, 255));
    else send_query($urandom_range(0, n), $urandom_range(0, n));
  endtask

  initial begin
    int unsigned n;
    bit [16:0] dv;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    write_reg(CFG_VERTEX_COUNT, 2);
    write_reg(CFG_STEP_COUNT, 63);
    write_reg(CFG_DECAY, 65536);
    write_reg(CFG_HALF_MODE, 0);
    build_graph(2);
    send_run();
    send_query(0, 1);
    send_query(1, 0);
    send_query(0, 0);
    send_query(1, 2);
    send_query(255, 255);
    send_query(0, 255);
    send_load(REQ_LOAD_OFFSET, 8191, 8191);
    send_load(REQ_LOAD_EDGE, 4096, 0);
    send_load(REQ_LOAD_EDGE, 4095, 8191);
    send_load(REQ_LOAD_OFFSET, 256, 4096);
    write_reg(CFG_VERTEX_COUNT, 0);
    send_query(0, 1);
    write_reg(CFG_VERTEX_COUNT, 511);
    send_query(0, 1);
    send_query(254, 255);
    write_reg(CFG_VERTEX_COUNT, 3);
    write_reg(CFG_STEP_COUNT, 0);
    write_reg(CFG_DECAY, 131071);
    write_reg(CFG_HALF_MODE, 1);
    build_graph(3);
    send_run();
    send_query(0, 1);
    send_query(2, 1);

    for (int ph = 0; ph < 6; ph++) begin
      n = (ph == 5) ? 12 : $urandom_range(2, 10);
      case ($urandom_range(0, 3))
        0: dv = 0;
        1: dv = 65536;
        2: dv = 17'($urandom);
        default: dv = 39322;
      endcase
      write_reg(CFG_VERTEX_COUNT, n);
      write_reg(CFG_STEP_COUNT, $urandom_range(1, 4));
      write_reg(CFG_DECAY, dv);
      write_reg(CFG_HALF_MODE, $urandom_range(0, 1));
      no_idle = (ph == 2);
      build_graph(n);
      send_run();
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 99) < 70) random_query(n);
        else send_load(req_e'($urandom_range(0, 1)), $urandom_range(0, 8191),
                       $urandom_range(0, 8191));
      end
      no_idle = 0;
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/srps_pkg.sv
hw/rtl/srps_ram.sv
hw/rtl/simrank_partial_sums_engine_top.sv
bench/simrank_partial_sums_engine_top_test.sv
